// ===== hdl/dbfr_pkg.sv =====
// Shared types, constants and codes of the double-buffer frame reader.
package dbfr_pkg;

  localparam int unsigned BufferDepth = 4096;
  localparam int unsigned FrameBits   = 32;
  localparam int unsigned AddrW       = $clog2(BufferDepth);
  localparam int unsigned SizeW       = AddrW + 1;
  localparam int unsigned BufFramesW  = 13;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned OutFrameW   = 32;
  localparam int unsigned InFrameW    = 32;
  localparam int unsigned InAddrW     = 12;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_REFILL  = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUFFER_FRAMES = 2'd0,
    CFG_STATIC_MODE   = 2'd1,
    CFG_LOOPING       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic from_store;
    logic counted;
    logic half_done;
    logic stopped;
  } res_t;

endpackage

// ===== hdl/dbfr_in_if.sv =====
// Request channel of the double-buffer frame reader.
interface dbfr_in_if
  import dbfr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [InAddrW-1:0]   address;
  logic [InFrameW-1:0]  frame_in;
  logic                 half_select;

  modport source (output valid, command, address, frame_in, half_select, input ready);
  modport sink (input valid, command, address, frame_in, half_select, output ready);
endinterface

// ===== hdl/dbfr_out_if.sv =====
// Result channel of the double-buffer frame reader.
interface dbfr_out_if
  import dbfr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OutFrameW-1:0] frame_out;
  logic                 from_store;
  logic                 counted;
  logic                 half_done;
  logic                 stopped;

  modport source (output valid, frame_out, from_store, counted, half_done, stopped,
                  input ready);
  modport sink (input valid, frame_out, from_store, counted, half_done, stopped,
                output ready);
endinterface

// ===== hdl/dbfr_ram.sv =====
// Single-port-write, single-port-read RAM with a registered read.
module dbfr_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/dbfr_ctrl.sv =====
// Playback control: configuration, read cursor, half flags and play state.
module dbfr_ctrl
  import dbfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 acc_i,
  input  logic [1:0]           command_i,
  input  logic                 half_select_i,
  output logic                 rd_en_o,
  output logic [AddrW-1:0]     rd_addr_o,
  output res_t                 res_o
);
  logic [BufFramesW-1:0] buffer_frames_q;
  logic                  static_mode_q;
  logic                  looping_q;
  logic [AddrW-1:0]      cursor_q, cursor_d;
  logic [1:0]            flags_q, flags_d;
  logic                  playing_q, playing_d;

  logic [SizeW-1:0]      bf_ext, size_clamp, size_even, size, half, end_idx, cur_ext;
  logic [AddrW-1:0]      cur_eff, cur_next;
  logic                  cur_half, at_end;
  res_t                  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_frames_q <= BufFramesW'(4096);
      static_mode_q   <= 1'b0;
      looping_q       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BUFFER_FRAMES: buffer_frames_q <= cfg_data_i[BufFramesW-1:0];
        CFG_STATIC_MODE:   static_mode_q   <= cfg_data_i[0];
        CFG_LOOPING:       looping_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bf_ext     = SizeW'(buffer_frames_q);
    size_clamp = (bf_ext > SizeW'(BufferDepth)) ? SizeW'(BufferDepth) : bf_ext;
    size_even  = {size_clamp[SizeW-1:1], 1'b0};
    size       = (size_even < SizeW'(2)) ? SizeW'(2) : size_even;
    half       = {1'b0, size[SizeW-1:1]};
    cur_eff    = ({1'b0, cursor_q} < size) ? cursor_q : '0;
    cur_ext    = {1'b0, cur_eff};
    cur_half   = (cur_ext >= half);
    end_idx    = (static_mode_q || cur_half) ? size - SizeW'(1) : half - SizeW'(1);
    at_end     = (cur_ext == end_idx);
    cur_next   = ((cur_ext + SizeW'(1)) >= size) ? '0 : cur_eff + AddrW'(1);
  end

  always_comb begin
    cursor_d       = cursor_q;
    flags_d        = flags_q;
    playing_d      = playing_q;
    res.from_store = 1'b0;
    res.counted    = 1'b0;
    res.half_done  = 1'b0;
    if (acc_i) begin
      unique case (cmd_e'(command_i))
        CMD_WRITE: ;
        CMD_REFILL: flags_d[half_select_i] = 1'b0;
        CMD_RESTART: begin
          playing_d = 1'b1;
          cursor_d  = '0;
        end
        CMD_READ: begin
          cursor_d = cur_eff;
          if (!playing_q) begin
            res.counted = !static_mode_q;
          end else if (!static_mode_q && flags_q[cur_half]) begin
            res.counted = 1'b1;
          end else begin
            res.from_store = 1'b1;
            res.counted    = 1'b1;
            cursor_d       = cur_next;
            if (at_end) begin
              flags_d[cur_half] = 1'b1;
              res.half_done     = 1'b1;
              if (!looping_q) begin
                playing_d = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
    res.stopped = !playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= '0;
      flags_q   <= 2'b11;
      playing_q <= 1'b0;
    end else begin
      cursor_q  <= cursor_d;
      flags_q   <= flags_d;
      playing_q <= playing_d;
    end
  end

  assign rd_en_o   = res.from_store;
  assign rd_addr_o = cur_eff;
  assign res_o     = res;

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && command_i == CMD_RESTART |=> playing_q && cursor_q == '0)
    else $error("restart did not start playback at frame zero");
  a_stop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && res.half_done && !looping_q |=> !playing_q)
    else $error("playback kept running after an end without looping");
  a_done_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && res.half_done |=> flags_q[$past(cur_half)])
    else $error("finished half was not flagged");
`endif
endmodule

// ===== hdl/double_buffer_frame_reader.sv =====
// Top level of the double-buffer frame reader.
// Requests arrive on in_if (valid/ready); each request gives exactly one
// result on out_if (valid/ready), in request order. A request is a frame
// write, a refill mark for one half, a one-frame read or a playback restart.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while
// no request is in flight.
// An accepted request's result passes through the frame store read stage
// and then the output register before it is valid on out_if.
// Throughput is one request per cycle unless the receiver stalls; the limit
// is the frame store's single read port, read at most once per read request.
// When the receiver stalls, one result waits in the output register and one
// in the read stage; in_if.ready drops only when both are full.
// Reset clears the cursor, marks both halves processed, stops playback and
// loads the default configuration. The frame store is not cleared and holds
// undefined data until written.
module double_buffer_frame_reader
  import dbfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dbfr_in_if.sink             in_if,
  dbfr_out_if.source          out_if
);
  logic                 acc;
  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [FrameBits-1:0] rdata;
  res_t                 res;

  logic                 s1_valid_q;
  res_t                 s1_res_q;
  logic                 out_valid_q;
  res_t                 out_res_q;
  logic [OutFrameW-1:0] out_frame_q;
  logic                 out_load;

  assign out_load    = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || out_load;
  assign acc         = in_if.valid && in_if.ready;

  dbfr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .acc_i         (acc),
    .command_i     (in_if.command),
    .half_select_i (in_if.half_select),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .res_o         (res)
  );

  dbfr_ram #(
    .Depth (BufferDepth),
    .Width (FrameBits)
  ) u_ram (
    .clk_i,
    .we_i    (acc && in_if.command == CMD_WRITE),
    .waddr_i (in_if.address[AddrW-1:0]),
    .wdata_i (in_if.frame_in[FrameBits-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= acc || (s1_valid_q && !out_load);
      out_valid_q <= out_load || (out_valid_q && !out_if.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_res_q <= res;
    end
    if (out_load) begin
      out_res_q   <= s1_res_q;
      out_frame_q <= s1_res_q.from_store ? OutFrameW'(rdata) : '0;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.frame_out  = out_frame_q;
  assign out_if.from_store = out_res_q.from_store;
  assign out_if.counted    = out_res_q.counted;
  assign out_if.half_done  = out_res_q.half_done;
  assign out_if.stopped    = out_res_q.stopped;

`ifndef SYNTHESIS
  a_silence_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.from_store |-> out_frame_q == '0)
    else $error("silent result carries frame data");
  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_if.ready |=> s1_valid_q && $stable(s1_res_q))
    else $error("read stage lost its result under a stall");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=>
      out_valid_q && $stable(out_frame_q) && $stable(out_res_q))
    else $error("result changed while the receiver stalled");
`endif
endmodule
